FILE: sv/mrmt_pkg.sv
// Shared types, constants and helper functions of the motion region menu trigger.
package mrmt_pkg;

    // Frame geometry
    localparam int FRAME_PIXELS = 6144;
    localparam int ROW_STRIDE   = 64;
    localparam int REGION_SIDE  = 4;
    localparam int NUM_REGIONS  = 3;
    localparam int NUM_SLOTS    = 3;

    localparam logic [12:0] REGION1_BASE = 13'd276;
    localparam logic [12:0] REGION2_BASE = 13'd286;
    localparam logic [12:0] REGION3_BASE = 13'd296;

    // Field widths
    localparam int IDX_W   = 13;
    localparam int PIX_W   = 8;
    localparam int FRAME_W = 16;
    localparam int SUM_W   = 12;
    localparam int AVG_W   = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Menu blink: quotient by BLINK_FRAMES via reciprocal multiply (exact for 16-bit)
    localparam int BLINK_FRAMES = 10;
    localparam int BLINK_SHIFT  = 19;
    localparam logic [16:0] BLINK_RECIP = 17'((2**BLINK_SHIFT + BLINK_FRAMES - 1) / BLINK_FRAMES);

    // Application modes
    localparam logic [MODE_W-1:0] MODE_MENU    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOPER  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAINTER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DIFF    = 2'd3;

    // Region select codes in the slot registers
    localparam logic [1:0] SEL_REGION1 = 2'd1;
    localparam logic [1:0] SEL_REGION2 = 2'd2;
    localparam logic [1:0] SEL_REGION3 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT1_REGION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT2_REGION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT3_REGION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FRAMES  = 3'd4;

    // Configuration reset values
    localparam logic [1:0] RST_SLOT1_REGION = SEL_REGION1;
    localparam logic [1:0] RST_SLOT2_REGION = SEL_REGION2;
    localparam logic [1:0] RST_SLOT3_REGION = SEL_REGION3;
    localparam logic [7:0] RST_THRESHOLD    = 8'd50;
    localparam logic [7:0] RST_INIT_FRAMES  = 8'd10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   pixel_index;
        logic [PIX_W-1:0]   pixel_value;
        logic               frame_end;
        logic [FRAME_W-1:0] frame_number;
    } in_item_t;

    typedef struct packed {
        logic [MODE_W-1:0] app_mode;
        logic              entered_app;
        logic              overlay_select;
    } out_item_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][1:0] slot_region;
        logic [7:0]                trigger_threshold;
        logic [7:0]                init_frames;
    } cfg_t;

    // One frame-end or return event handed from front to back
    typedef struct packed {
        logic                             is_return;
        logic [NUM_REGIONS-1:0][SUM_W-1:0] region_sum;
        logic [FRAME_W-1:0]               frame_number;
        logic                             blink;
    } event_t;

    function automatic logic [IDX_W-1:0] region_base(input int r);
        logic [IDX_W-1:0] b;
        unique case (r)
            1:       b = REGION2_BASE;
            2:       b = REGION3_BASE;
            default: b = REGION1_BASE;
        endcase
        return b;
    endfunction

    // True when idx lies in the 4x4 block whose top-left pixel is base
    function automatic logic in_region(input logic [IDX_W-1:0] idx,
                                       input logic [IDX_W-1:0] base);
        logic [31:0] off;
        logic        hit;
        off = 32'(idx) - 32'(base);
        hit = 1'b0;
        if (idx >= base) begin
            for (int row = 0; row < REGION_SIDE; row++) begin
                if (off >= 32'(row * ROW_STRIDE) &&
                    off < 32'(row * ROW_STRIDE + REGION_SIDE))
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

FILE: sv/mrmt_front.sv
// Front part: accepts pixels, accumulates region sums and emits frame-end and return events.
module mrmt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mrmt_pkg::in_item_t  item,
    output logic                push,
    output mrmt_pkg::event_t    push_data
);

    logic [mrmt_pkg::NUM_REGIONS-1:0][mrmt_pkg::SUM_W-1:0] sum_reg;
    logic [mrmt_pkg::NUM_REGIONS-1:0][mrmt_pkg::SUM_W-1:0] sum_next;
    logic [mrmt_pkg::NUM_REGIONS-1:0][mrmt_pkg::SUM_W-1:0] sum_added;
    logic [32:0] blink_prod;
    logic        idx_ok;

    assign idx_ok = 32'(item.pixel_index) < 32'(mrmt_pkg::FRAME_PIXELS);

    always_comb
    begin
        for (int r = 0; r < mrmt_pkg::NUM_REGIONS; r++) begin
            logic [mrmt_pkg::SUM_W:0] s;
            s = {1'b0, sum_reg[r]} + (mrmt_pkg::SUM_W+1)'(item.pixel_value);
            if (idx_ok && mrmt_pkg::in_region(item.pixel_index, mrmt_pkg::region_base(r)))
            begin
                sum_added[r] = s[mrmt_pkg::SUM_W] ? mrmt_pkg::SUM_MAX
                                                  : s[mrmt_pkg::SUM_W-1:0];
            end
            else
            begin
                sum_added[r] = sum_reg[r];
            end
        end
    end

    // Menu blink: bit 0 of frame_number / BLINK_FRAMES, inverted
    assign blink_prod = 33'(item.frame_number) * 33'(mrmt_pkg::BLINK_RECIP);

    assign push = accept && (item.cmd || item.frame_end);

    always_comb
    begin
        push_data.is_return    = item.cmd;
        push_data.region_sum   = sum_added;
        push_data.frame_number = item.frame_number;
        push_data.blink        = ~blink_prod[mrmt_pkg::BLINK_SHIFT];
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (accept) begin
            if (item.cmd || item.frame_end) begin
                sum_next = '0;
            end
            else
            begin
                sum_next = sum_added;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

FILE: sv/mrmt_queue.sv
// Short event queue between the front and back parts.
module mrmt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrmt_pkg::event_t  push_data,
    output logic              full,
    input  logic              pop,
    output mrmt_pkg::event_t  pop_data,
    output logic              empty
);

    mrmt_pkg::event_t                 entry_reg [mrmt_pkg::QUEUE_DEPTH];
    logic [mrmt_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mrmt_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mrmt_pkg::QUEUE_PTR_W:0]   count_reg, count_next;

    assign full     = count_reg == (mrmt_pkg::QUEUE_PTR_W+1)'(mrmt_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/mrmt_back.sv
// Back part: slot checks, running averages, mode and the registered result.
module mrmt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mrmt_pkg::cfg_t     cfg,
    input  logic               empty,
    input  mrmt_pkg::event_t   ev,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output mrmt_pkg::out_item_t out_data
);

    logic [mrmt_pkg::NUM_SLOTS-1:0][mrmt_pkg::AVG_W-1:0] avg_reg, avg_next;
    logic [mrmt_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic                          out_valid_reg;
    mrmt_pkg::out_item_t           out_data_reg;
    mrmt_pkg::out_item_t           result;

    logic [mrmt_pkg::NUM_SLOTS-1:0][mrmt_pkg::AVG_W-1:0] upd_avg;
    logic [mrmt_pkg::NUM_SLOTS-1:0]                      trig;
    logic                                                check_en;

    assign pop       = !empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign check_en = (mode_reg == mrmt_pkg::MODE_MENU) &&
                      (ev.frame_number >= {8'h00, cfg.init_frames});

    // Per-slot check, all slots side by side
    always_comb
    begin
        for (int s = 0; s < mrmt_pkg::NUM_SLOTS; s++) begin
            logic [1:0]                  ri;
            logic [mrmt_pkg::AVG_W-1:0]  mean;
            logic [mrmt_pkg::AVG_W-1:0]  avg;
            logic [mrmt_pkg::AVG_W-1:0]  delta;
            logic [mrmt_pkg::AVG_W:0]    total;
            unique case (cfg.slot_region[s])
                mrmt_pkg::SEL_REGION2: ri = 2'd1;
                mrmt_pkg::SEL_REGION3: ri = 2'd2;
                default:               ri = 2'd0;
            endcase
            mean  = {ev.region_sum[ri], 4'h0};
            avg   = avg_reg[s];
            delta = (mean > avg) ? mean - avg : avg - mean;
            total = {1'b0, avg} + {1'b0, mean};
            if (avg == '0) begin
                trig[s]    = 1'b0;
                upd_avg[s] = mean;
            end
            else
            begin
                trig[s]    = delta > {cfg.trigger_threshold, 8'h00};
                upd_avg[s] = total[mrmt_pkg::AVG_W:1];
            end
        end
    end

    always_comb
    begin
        logic stop;
        avg_next  = avg_reg;
        mode_next = mode_reg;
        result    = '0;
        stop      = 1'b0;
        if (pop) begin
            if (ev.is_return) begin
                avg_next  = '0;
                mode_next = mrmt_pkg::MODE_MENU;
            end
            else if (check_en)
            begin
                // Walk slots in order; the first trigger wins and skips the rest
                for (int s = 0; s < mrmt_pkg::NUM_SLOTS; s++) begin
                    if (!stop) begin
                        if (trig[s]) begin
                            stop               = 1'b1;
                            mode_next          = mrmt_pkg::MODE_W'(s + 1);
                            result.entered_app = 1'b1;
                        end
                        else
                        begin
                            avg_next[s] = upd_avg[s];
                        end
                    end
                end
            end
            result.app_mode       = mode_next;
            result.overlay_select = (mode_next == mrmt_pkg::MODE_MENU) ? ev.blink : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            avg_reg       <= '0;
            mode_reg      <= mrmt_pkg::MODE_MENU;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            avg_reg  <= avg_next;
            mode_reg <= mode_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: sv/motion_region_menu_trigger_core.sv
// Top level of the motion region menu trigger: front, event queue, back and config registers.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data  (cmd, pixel, frame_end, frame_number)
// out       output     out_valid / out_ready   out_data (app_mode, entered_app, overlay_select)
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel transfer per clock while in_ready is high. A frame end or return command is
// queued as an event (4 deep) at its input transfer; the back part pops it once its
// output register is free, and the slot checks settle ahead of the output register,
// which holds the result on out until it transfers. in_ready drops only while the
// event queue is full, which needs the output to be stalled. Reset clears sums,
// averages, mode and queue, and loads the register defaults; cfg_ready is always high.
module motion_region_menu_trigger_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mrmt_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mrmt_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrmt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrmt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mrmt_pkg::cfg_t   cfg_reg, cfg_next;
    mrmt_pkg::event_t push_data;
    mrmt_pkg::event_t pop_data;
    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    // Accept pixels whenever the queue has room for a possible event
    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Register writes; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                mrmt_pkg::CFG_SLOT1_REGION: cfg_next.slot_region[0]    = cfg_data[1:0];
                mrmt_pkg::CFG_SLOT2_REGION: cfg_next.slot_region[1]    = cfg_data[1:0];
                mrmt_pkg::CFG_SLOT3_REGION: cfg_next.slot_region[2]    = cfg_data[1:0];
                mrmt_pkg::CFG_THRESHOLD:    cfg_next.trigger_threshold = cfg_data;
                mrmt_pkg::CFG_INIT_FRAMES:  cfg_next.init_frames       = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.slot_region[0]    <= mrmt_pkg::RST_SLOT1_REGION;
            cfg_reg.slot_region[1]    <= mrmt_pkg::RST_SLOT2_REGION;
            cfg_reg.slot_region[2]    <= mrmt_pkg::RST_SLOT3_REGION;
            cfg_reg.trigger_threshold <= mrmt_pkg::RST_THRESHOLD;
            cfg_reg.init_frames       <= mrmt_pkg::RST_INIT_FRAMES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accumulate region sums, emit events on frame end and return
    mrmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_data),
        .push      (push),
        .push_data (push_data)
    );

    // Hold events until the back part is free
    mrmt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back: slot checks, averages, mode, result register
    mrmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (empty),
        .ev        (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: test/motion_region_menu_trigger_core_test.sv
// Self-checking testbench for the motion region menu trigger core.
module motion_region_menu_trigger_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrmt_pkg::*;

    // Random part length, phase length, drain time after the last result, shown fault limit
    localparam int RANDOM_ITEMS = 1600;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 10;
    localparam int SHOWN_FAULTS = 10;

    // Slot select value that names no region; the block falls back to region one
    localparam logic [1:0] SEL_NONE = 2'd0;

    // Receiver stall styles
    localparam int STALL_NONE    = 0;
    localparam int STALL_PATTERN = 1;
    localparam int STALL_RANDOM  = 2;

    typedef struct packed {
        in_item_t  item;
        logic      pinned;
        out_item_t result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: region sums, slot averages in Q8.8, mode and register copies
    logic [SUM_W-1:0] region_total [NUM_REGIONS];
    logic [AVG_W-1:0] slot_average [NUM_SLOTS];
    logic [1:0]       slot_select  [NUM_SLOTS];
    logic [MODE_W-1:0] app_mode_now;
    logic [7:0]       threshold_now;
    logic [7:0]       init_frames_now;

    // Results still owed by the block, oldest first
    out_item_t pending_results [$];
    stim_row_t directed_rows [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;
    int stall_mode     = STALL_NONE;
    int stall_left     = 0;
    logic [15:0] stall_word = 16'hFFFF;

    // Stimulus generator state
    logic [FRAME_W-1:0] frame_ctr;
    logic [7:0]         region_level [NUM_REGIONS];

    motion_region_menu_trigger_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop; a correct run needs well under a fifth of this
    initial
    begin
        #2_000_000;
        $display("motion_region_menu_trigger_core verification failed");
        $finish;
    end

    // Top-left pixel of each 4x4 block
    function automatic logic [IDX_W-1:0] block_origin(input int r);
        if (r == 1)
            return REGION2_BASE;
        if (r == 2)
            return REGION3_BASE;
        return REGION1_BASE;
    endfunction

    function automatic logic pixel_in_block(input logic [IDX_W-1:0] idx,
                                            input logic [IDX_W-1:0] origin);
        int unsigned off;
        if (idx < origin)
            return 1'b0;
        off = idx - origin;
        return (off / ROW_STRIDE) < REGION_SIDE && (off % ROW_STRIDE) < REGION_SIDE;
    endfunction

    // Menu blink: overlay one while the tens digit of the frame count is even
    function automatic logic menu_blink(input logic [FRAME_W-1:0] frame);
        return ((frame / BLINK_FRAMES) % 2) == 0;
    endfunction

    function automatic void clear_predictor();
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            region_total[r] = '0;
            slot_average[r] = '0;
        end
        app_mode_now = MODE_MENU;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_SLOT1_REGION: slot_select[0] = data[1:0];
            CFG_SLOT2_REGION: slot_select[1] = data[1:0];
            CFG_SLOT3_REGION: slot_select[2] = data[1:0];
            CFG_THRESHOLD:    threshold_now = data;
            CFG_INIT_FRAMES:  init_frames_now = data;
            default: ;
        endcase
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a result is due
    function automatic logic trigger_step(input in_item_t item, output out_item_t res);
        logic [SUM_W:0]    total;
        logic [AVG_W-1:0]  mean;
        logic [AVG_W-1:0]  avg;
        logic [AVG_W-1:0]  delta;
        logic [AVG_W:0]    both;
        logic              fired;
        int                sel;
        res   = '0;
        fired = 1'b0;
        if (item.cmd)
        begin
            clear_predictor();
            res.app_mode       = MODE_MENU;
            res.overlay_select = menu_blink(item.frame_number);
            return 1'b1;
        end
        if (item.pixel_index < FRAME_PIXELS)
        begin
            for (int r = 0; r < NUM_REGIONS; r++)
            begin
                if (pixel_in_block(item.pixel_index, block_origin(r)))
                begin
                    total = region_total[r] + item.pixel_value;
                    region_total[r] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
                end
            end
        end
        if (!item.frame_end)
            return 1'b0;
        if (app_mode_now == MODE_MENU && item.frame_number >= init_frames_now)
        begin
            for (int s = 0; s < NUM_SLOTS && !fired; s++)
            begin
                case (slot_select[s])
                    SEL_REGION2: sel = 1;
                    SEL_REGION3: sel = 2;
                    default:     sel = 0;
                endcase
                mean = {region_total[sel], 4'b0000};
                avg  = slot_average[s];
                if (avg == '0)
                    slot_average[s] = mean;  // unset slot: load, no motion check
                else
                begin
                    delta = (mean > avg) ? mean - avg : avg - mean;
                    if (delta > {threshold_now, 8'h00})
                    begin
                        fired = 1'b1;
                        case (s)
                            0:       app_mode_now = MODE_LOOPER;
                            1:       app_mode_now = MODE_PAINTER;
                            default: app_mode_now = MODE_DIFF;
                        endcase
                    end
                    else
                    begin
                        both = avg + mean;
                        slot_average[s] = both[AVG_W:1];
                    end
                end
            end
        end
        for (int r = 0; r < NUM_REGIONS; r++)
            region_total[r] = '0;
        res.app_mode       = app_mode_now;
        res.entered_app    = fired;
        res.overlay_select = (app_mode_now == MODE_MENU) ? menu_blink(item.frame_number)
                                                         : 1'b0;
        return 1'b1;
    endfunction

    // Present one item in a burst of random length, hold it until the transfer,
    // then record what the block owes for it
    task automatic send_item(input in_item_t item, input logic pinned,
                             input out_item_t pinned_res);
        out_item_t predicted;
        logic      produced;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        produced = trigger_step(item, predicted);
        if (produced)
            pending_results.push_back(pinned ? pinned_res : predicted);
        items_sent++;
    endtask

    // Drop valid and wait for every owed result plus the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(index, data);
    endtask

    task automatic load_settings(input logic [1:0] s1, input logic [1:0] s2,
                                 input logic [1:0] s3, input logic [7:0] thr,
                                 input logic [7:0] init);
        write_register(CFG_SLOT1_REGION, {6'b0, s1});
        write_register(CFG_SLOT2_REGION, {6'b0, s2});
        write_register(CFG_SLOT3_REGION, {6'b0, s3});
        write_register(CFG_THRESHOLD, thr);
        write_register(CFG_INIT_FRAMES, init);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] clamp_level(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    function automatic logic [IDX_W-1:0] block_pixel(input int r);
        return IDX_W'(block_origin(r) + $urandom_range(0, 3) * ROW_STRIDE
                      + $urandom_range(0, 3));
    endfunction

    function automatic void add_row(input logic c, input int idx, input int val,
                                    input logic fend, input int frame,
                                    input logic pinned = 1'b0,
                                    input logic [1:0] mode = MODE_MENU,
                                    input logic entered = 1'b0,
                                    input logic overlay = 1'b0);
        stim_row_t row;
        row.item.cmd            = c;
        row.item.pixel_index    = IDX_W'(idx);
        row.item.pixel_value    = PIX_W'(val);
        row.item.frame_end      = fend;
        row.item.frame_number   = FRAME_W'(frame);
        row.pinned              = pinned;
        row.result.app_mode     = mode;
        row.result.entered_app  = entered;
        row.result.overlay_select = overlay;
        directed_rows.push_back(row);
    endfunction

    // One frame of camera traffic: a few pixels per region around a per-region
    // level that mostly drifts and sometimes jumps, a little off-region noise,
    // then the frame end. Now and then one region is flooded so its sum saturates.
    task automatic run_frame();
        in_item_t it;
        int       count;
        int       flood;
        int       roll;
        it = '0;
        it.frame_number = frame_ctr;
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                region_level[r] = clamp_level(int'(region_level[r]) + $urandom_range(0, 8) - 4);
            else if (roll < 85)
                region_level[r] = 8'($urandom_range(0, 255));
            else if (roll < 93)
                region_level[r] = 8'd0;
            else
                region_level[r] = 8'd255;
        end
        flood = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 2) : -1;
        for (int r = 0; r < NUM_REGIONS; r++)
        begin
            count = (r == flood) ? 18 : $urandom_range(0, 6);
            for (int k = 0; k < count; k++)
            begin
                it.pixel_index = block_pixel(r);
                it.pixel_value = (r == flood) ? 8'($urandom_range(230, 255))
                                 : clamp_level(int'(region_level[r]) + $urandom_range(0, 6) - 3);
                send_item(it, 1'b0, '0);
            end
        end
        // Off-region noise: near misses beside a block, or anywhere in the index range
        count = $urandom_range(0, 2);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                it.pixel_index = IDX_W'(block_origin($urandom_range(0, 2))
                                        + $urandom_range(0, 3) * ROW_STRIDE
                                        + $urandom_range(4, ROW_STRIDE - 1));
            else
                it.pixel_index = IDX_W'($urandom_range(0, 8191));
            it.pixel_value = 8'($urandom);
            send_item(it, 1'b0, '0);
        end
        // A stray return command in the middle of a frame
        if ($urandom_range(0, 32) == 0)
        begin
            it.cmd = 1'b1;
            it.frame_end = 1'($urandom);
            send_item(it, 1'b0, '0);
            it.cmd = 1'b0;
        end
        it.frame_end = 1'b1;
        it.pixel_index = ($urandom_range(0, 1) == 0) ? block_pixel($urandom_range(0, 2))
                                                     : IDX_W'($urandom_range(0, 8191));
        it.pixel_value = 8'($urandom);
        if ($urandom_range(0, 24) == 0)
            it.frame_number = FRAME_W'($urandom);  // out-of-sequence frame count
        send_item(it, 1'b0, '0);
        frame_ctr = (frame_ctr == 16'hFFFF) ? frame_ctr : frame_ctr + 1'b1;
        // Leave an app again soon so the menu checks keep running
        if (app_mode_now != MODE_MENU && $urandom_range(0, 9) < 6)
        begin
            it.cmd            = 1'b1;
            it.pixel_index    = IDX_W'($urandom);
            it.pixel_value    = 8'($urandom);
            it.frame_end      = 1'($urandom);
            it.frame_number   = frame_ctr;
            send_item(it, 1'b0, '0);
        end
    endtask

    // Receiver: check each transfer against the oldest owed result, then pick
    // out_ready for the next edge from the current stall style
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_FAULTS)
                    $display("unexpected result: mode %0d entered %0b overlay %0b",
                             out_data.app_mode, out_data.entered_app,
                             out_data.overlay_select);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.app_mode !== want.app_mode ||
                    out_data.entered_app !== want.entered_app ||
                    out_data.overlay_select !== want.overlay_select)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_FAULTS)
                        $display({"result mismatch: expected mode %0d entered %0b ",
                                  "overlay %0b, got mode %0d entered %0b overlay %0b"},
                                 want.app_mode, want.entered_app, want.overlay_select,
                                 out_data.app_mode, out_data.entered_app,
                                 out_data.overlay_select);
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(STALL_NONE, STALL_RANDOM);
            stall_left = $urandom_range(32, 300);
            stall_word = 16'($urandom) | 16'h0001;
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:
                out_ready <= 1'b1;
            STALL_PATTERN:
            begin
                out_ready <= stall_word[0];
                stall_word = {stall_word[0], stall_word[15:1]};
            end
            default:
                out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial
    begin
        stim_row_t row;
        int        phase;
        int        phase_end;
        int        random_goal;
        logic [1:0] s1, s2, s3;
        logic [7:0] thr, init;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SLOT1_REGION;
        cfg_data  <= '0;
        clear_predictor();
        slot_select[0]  = RST_SLOT1_REGION;
        slot_select[1]  = RST_SLOT2_REGION;
        slot_select[2]  = RST_SLOT3_REGION;
        threshold_now   = RST_THRESHOLD;
        init_frames_now = RST_INIT_FRAMES;
        for (int r = 0; r < NUM_REGIONS; r++)
            region_level[r] = 8'($urandom);

        // Directed rows, run with the reset register values. Pinned rows carry the
        // result typed in; the rest are checked against the predictor.
        add_row(1, 0, 0, 0, 0, 1, MODE_MENU, 0, 1);          // return right after reset
        add_row(0, 0, 0, 1, 0, 1, MODE_MENU, 0, 1);          // frame end before init frames
        add_row(0, 8191, 255, 1, 9, 1, MODE_MENU, 0, 1);     // index out of range, all bits high
        add_row(0, 6143, 255, 0, 9);                         // last index in the frame
        add_row(0, 276, 255, 0, 10);                         // region one corners
        add_row(0, 279, 255, 0, 10);
        add_row(0, 468, 255, 0, 10);
        add_row(0, 471, 255, 0, 10);
        add_row(0, 286, 1, 0, 10);                           // region two, tiny mean
        add_row(0, 491, 128, 0, 10);                         // region three, bottom right
        add_row(0, 280, 255, 1, 10);                         // first check: averages load
        add_row(0, 340, 0, 1, 20);                           // region one drops: slot one fires
        add_row(0, 0, 0, 1, 21, 1, MODE_LOOPER, 0, 0);       // app mode: no check, overlay off
        add_row(1, 276, 255, 1, 65535, 1, MODE_MENU, 0, 0);  // return ignores pixel fields
        add_row(0, 0, 0, 1, 30);                             // zero means keep slots unset
        add_row(0, 296, 255, 0, 40);
        add_row(0, 286, 200, 0, 40);
        add_row(0, 0, 0, 1, 40);                             // slots two and three load
        add_row(0, 286, 255, 0, 41);
        add_row(0, 287, 255, 0, 41);
        add_row(0, 288, 255, 0, 41);
        add_row(0, 289, 255, 0, 41);
        add_row(0, 0, 0, 1, 41);                             // region two jumps: slot two fires
        add_row(1, 0, 0, 0, 0, 1, MODE_MENU, 0, 1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.item, row.pinned, row.result);
        end

        // Random phases, each under its own register settings; the first few
        // pin the defaults and the extremes, the rest draw at random
        random_goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_goal)
        begin
            settle();
            case (phase)
                0:
                begin
                    load_settings(SEL_REGION1, SEL_REGION2, SEL_REGION3,
                                  RST_THRESHOLD, RST_INIT_FRAMES);
                    frame_ctr = '0;
                end
                1:
                begin
                    load_settings(SEL_NONE, SEL_NONE, SEL_NONE, 8'd0, 8'd0);
                    frame_ctr = '0;
                end
                2:
                begin
                    load_settings(SEL_REGION3, SEL_REGION2, SEL_REGION1, 8'd255, 8'd255);
                    frame_ctr = 16'd240;
                end
                3:
                begin
                    load_settings(SEL_REGION2, SEL_REGION2, SEL_REGION2, 8'd255, 8'd0);
                    frame_ctr = 16'd65520;
                end
                default:
                begin
                    s1  = 2'($urandom);
                    s2  = 2'($urandom);
                    s3  = 2'($urandom);
                    thr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
                    init = 8'($urandom);
                    load_settings(s1, s2, s3, thr, init);
                    case ($urandom_range(0, 3))
                        0, 1:    frame_ctr = FRAME_W'($urandom_range(0, 300));
                        2:       frame_ctr = FRAME_W'($urandom);
                        default: frame_ctr = FRAME_W'($urandom_range(65500, 65535));
                    endcase
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                run_frame();
            phase++;
        end

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("motion_region_menu_trigger_core verification clean");
        else
            $display("motion_region_menu_trigger_core verification failed");
        $finish;
    end

endmodule
